### hdl/qrr_pkg.sv
// qrr_pkg: shared types and constants for the quadratic real-root pipeline.
// No dependencies.
package qrr_pkg;

  // Width of each root on the result channel (signed fixed point).
  localparam int OUT_WIDTH = 34;

  // Pipeline control handed from the top level to the arithmetic units.
  typedef struct packed {
    logic adv;  // every stage moves one step this cycle
  } pipe_ctl_t;

endpackage

### hdl/qrr_sqrt.sv
// qrr_sqrt: pipelined floor square root, one result bit per register stage.
// Depends on qrr_pkg (pipe_ctl_t). Carries a sideband word alongside the data.
module qrr_sqrt import qrr_pkg::*; #(
  parameter int XW  = 65,
  parameter int SBW = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_ctl_t                ctl,
  input  logic                     in_v,
  input  logic [XW-1:0]            in_x,
  input  logic [SBW-1:0]           in_sb,
  output logic                     out_v,
  output logic [(XW+1)/2-1:0]      out_root,
  output logic [SBW-1:0]           out_sb
);

  localparam int RW  = (XW + 1) / 2;
  localparam int XP  = 2 * RW;
  localparam int RMW = RW + 3;

  logic           v_r    [RW];
  logic [XP-1:0]  x_r    [RW];
  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [SBW-1:0] sb_r   [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic           v_i;
    logic [XP-1:0]  x_i;
    logic [RMW-1:0] rem_i;
    logic [RW-1:0]  root_i;
    logic [SBW-1:0] sb_i;
    logic [RMW-1:0] rem_n;
    logic [RMW-1:0] trial;
    logic           ge;

    if (g == 0) begin : g_first
      assign v_i    = in_v;
      assign x_i    = XP'(in_x);
      assign rem_i  = '0;
      assign root_i = '0;
      assign sb_i   = in_sb;
    end else begin : g_next
      assign v_i    = v_r[g-1];
      assign x_i    = x_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign sb_i   = sb_r[g-1];
    end

    // Bring down the next bit pair, try to subtract 4*root+1.
    assign rem_n = {rem_i[RMW-3:0], x_i[XP-1 -: 2]};
    assign trial = RMW'({root_i, 2'b01});
    assign ge    = (rem_n >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (ctl.adv) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        x_r[g]    <= {x_i[XP-3:0], 2'b00};
        rem_r[g]  <= ge ? (rem_n - trial) : rem_n;
        root_r[g] <= {root_i[RW-2:0], ge};
        sb_r[g]   <= sb_i;
      end
    end
  end

  assign out_v    = v_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_sb   = sb_r[RW-1];

endmodule

### hdl/qrr_div.sv
// qrr_div: two pipelined restoring dividers sharing one signed denominator.
// Depends on qrr_pkg (pipe_ctl_t). Returns quotient magnitudes and signs.
module qrr_div import qrr_pkg::*; #(
  parameter int NW  = 35,
  parameter int DW  = 17,
  parameter int SBW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pipe_ctl_t            ctl,
  input  logic                 in_v,
  input  logic signed [NW-1:0] in_np,
  input  logic signed [NW-1:0] in_nm,
  input  logic signed [DW-1:0] in_den,
  input  logic [SBW-1:0]       in_sb,
  output logic                 out_v,
  output logic [NW-1:0]        out_qp,
  output logic [NW-1:0]        out_qm,
  output logic                 out_negp,
  output logic                 out_negm,
  output logic [SBW-1:0]       out_sb
);

  // Magnitude stage.
  logic           pv_r;
  logic [NW-1:0]  pn_r [2];
  logic [DW-1:0]  pd_r;
  logic [1:0]     pneg_r;
  logic [SBW-1:0] psb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ctl.adv) begin
      pv_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      pn_r[0]   <= in_np[NW-1] ? NW'(-in_np) : NW'(in_np);
      pn_r[1]   <= in_nm[NW-1] ? NW'(-in_nm) : NW'(in_nm);
      pd_r      <= in_den[DW-1] ? DW'(-in_den) : DW'(in_den);
      pneg_r[0] <= in_np[NW-1] ^ in_den[DW-1];
      pneg_r[1] <= in_nm[NW-1] ^ in_den[DW-1];
      psb_r     <= in_sb;
    end
  end

  // One quotient bit per stage; the numerator register shifts the quotient in.
  logic           v_r   [NW];
  logic [NW-1:0]  n_r   [NW][2];
  logic [DW:0]    rem_r [NW][2];
  logic [DW-1:0]  d_r   [NW];
  logic [1:0]     neg_r [NW];
  logic [SBW-1:0] sb_r  [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic           v_i;
    logic [DW-1:0]  d_i;
    logic [1:0]     neg_i;
    logic [SBW-1:0] sb_i;

    if (g == 0) begin : g_first
      assign v_i   = pv_r;
      assign d_i   = pd_r;
      assign neg_i = pneg_r;
      assign sb_i  = psb_r;
    end else begin : g_next
      assign v_i   = v_r[g-1];
      assign d_i   = d_r[g-1];
      assign neg_i = neg_r[g-1];
      assign sb_i  = sb_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (ctl.adv) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        d_r[g]   <= d_i;
        neg_r[g] <= neg_i;
        sb_r[g]  <= sb_i;
      end
    end

    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [NW-1:0] n_i;
      logic [DW:0]   rem_i;
      logic [DW:0]   rem_n;
      logic          ge;

      if (g == 0) begin : g_first
        assign n_i   = pn_r[j];
        assign rem_i = '0;
      end else begin : g_next
        assign n_i   = n_r[g-1][j];
        assign rem_i = rem_r[g-1][j];
      end

      assign rem_n = {rem_i[DW-1:0], n_i[NW-1]};
      assign ge    = (rem_n >= {1'b0, d_i});

      always_ff @(posedge clk) begin
        if (ctl.adv) begin
          rem_r[g][j] <= ge ? (rem_n - {1'b0, d_i}) : rem_n;
          n_r[g][j]   <= {n_i[NW-2:0], ge};
        end
      end
    end
  end

  assign out_v    = v_r[NW-1];
  assign out_qp   = n_r[NW-1][0];
  assign out_qm   = n_r[NW-1][1];
  assign out_negp = neg_r[NW-1][0];
  assign out_negm = neg_r[NW-1][1];
  assign out_sb   = sb_r[NW-1];

endmodule

### hdl/quadratic_real_roots.sv
// quadratic_real_roots: top level of the pipelined quadratic root solver.
// Depends on qrr_pkg, qrr_sqrt and qrr_div.

// Solves a*x^2 + b*x + c for its two real roots. Each request carries signed
// integer coefficients; each result carries (-b + sqrt(D)) / 2a and
// (-b - sqrt(D)) / 2a in signed fixed point with FRAC_BITS fraction bits,
// where D = b*b - 4ac and sqrt(D) is the floor square root taken at the
// fraction scale. Quotients truncate toward zero and saturate to 34 bits.
// When a is zero or D is not positive, no_real_roots is set and both roots
// are zero. A new request is taken every cycle unless in_stall is set; it passes
// the product and discriminant stages, the square root (one bit per stage),
// the numerator stage, a magnitude stage, the division (one quotient bit per
// stage) and the output register. The whole pipeline holds while a finished
// result is stalled on the output, so in_stall follows out_stall only then.
module quadratic_real_roots import qrr_pkg::*; #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  logic signed [COEF_WIDTH-1:0] in_coef_c,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [OUT_WIDTH-1:0]  out_root_plus,
  output logic signed [OUT_WIDTH-1:0]  out_root_minus,
  output logic                         out_no_real_roots
);

  localparam int W    = COEF_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * W;          // product width
  localparam int SW   = 2 * W + 3;      // signed discriminant width
  localparam int DW   = 2 * W + 1;      // discriminant magnitude width
  localparam int XW   = DW + 2 * F;     // scaled discriminant
  localparam int RW   = (XW + 1) / 2;   // square root width
  localparam int NW   = W + F + 3;      // numerator width
  localparam int DENW = W + 1;          // 2a width
  localparam int SBW  = 2 * W + 1;      // {flag, a, b} through the root
  localparam int QW   = NW + 1;         // signed quotient
  localparam int CW   = (QW > OUT_WIDTH) ? QW : OUT_WIDTH;

  pipe_ctl_t ctl;
  logic      out_valid_r;

  // Whole pipeline moves unless a finished result is being held.
  assign ctl.adv  = !out_valid_r || !out_stall;
  assign in_stall = !ctl.adv;

  // Stage 1: products b*b and a*c.
  logic                 s1_v_r;
  logic signed [PW-1:0] s1_bb_r;
  logic signed [PW-1:0] s1_ac_r;
  logic signed [W-1:0]  s1_a_r;
  logic signed [W-1:0]  s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ctl.adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s1_bb_r <= in_coef_b * in_coef_b;
      s1_ac_r <= in_coef_a * in_coef_c;
      s1_a_r  <= in_coef_a;
      s1_b_r  <= in_coef_b;
    end
  end

  // Stage 2: discriminant and the no-root flag.
  logic signed [SW-1:0] disc;
  logic                 s2_v_r;
  logic [DW-1:0]        s2_d_r;
  logic                 s2_flag_r;
  logic signed [W-1:0]  s2_a_r;
  logic signed [W-1:0]  s2_b_r;

  assign disc = SW'(s1_bb_r) - (SW'(s1_ac_r) <<< 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ctl.adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s2_d_r    <= DW'(disc);
      s2_flag_r <= (s1_a_r == '0) || disc[SW-1] || (disc == '0);
      s2_a_r    <= s1_a_r;
      s2_b_r    <= s1_b_r;
    end
  end

  // Square root of D * 2^(2F).
  logic [XW-1:0]  sq_x;
  logic           sq_v;
  logic [RW-1:0]  sq_root;
  logic [SBW-1:0] sq_sb;

  assign sq_x = XW'(s2_d_r) << (2 * F);

  qrr_sqrt #(
    .XW  (XW),
    .SBW (SBW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_v     (s2_v_r),
    .in_x     (sq_x),
    .in_sb    ({s2_flag_r, s2_a_r, s2_b_r}),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  // Stage 3: numerators -b*2^F +/- s and denominator 2a.
  logic signed [W-1:0]    sq_a;
  logic signed [W-1:0]    sq_b;
  logic signed [NW-1:0]   nb;
  logic                   s3_v_r;
  logic signed [NW-1:0]   s3_np_r;
  logic signed [NW-1:0]   s3_nm_r;
  logic signed [DENW-1:0] s3_den_r;
  logic                   s3_flag_r;

  assign sq_a = sq_sb[2*W-1:W];
  assign sq_b = sq_sb[W-1:0];
  assign nb   = -(NW'(sq_b) <<< F);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (ctl.adv) begin
      s3_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s3_np_r   <= nb + $signed(NW'(sq_root));
      s3_nm_r   <= nb - $signed(NW'(sq_root));
      s3_den_r  <= DENW'(sq_a) <<< 1;
      s3_flag_r <= sq_sb[SBW-1];
    end
  end

  // Division, both roots side by side.
  logic          dv_v;
  logic [NW-1:0] dv_qp;
  logic [NW-1:0] dv_qm;
  logic          dv_negp;
  logic          dv_negm;
  logic          dv_flag;

  qrr_div #(
    .NW  (NW),
    .DW  (DENW),
    .SBW (1)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_v     (s3_v_r),
    .in_np    (s3_np_r),
    .in_nm    (s3_nm_r),
    .in_den   (s3_den_r),
    .in_sb    (s3_flag_r),
    .out_v    (dv_v),
    .out_qp   (dv_qp),
    .out_qm   (dv_qm),
    .out_negp (dv_negp),
    .out_negm (dv_negm),
    .out_sb   (dv_flag)
  );

  // Output stage: apply sign, saturate, clear on no-root.
  logic signed [CW-1:0] q_max;
  logic signed [CW-1:0] q_min;
  logic signed [CW-1:0] qp;
  logic signed [CW-1:0] qm;
  logic signed [OUT_WIDTH-1:0] qp_sat;
  logic signed [OUT_WIDTH-1:0] qm_sat;
  logic signed [OUT_WIDTH-1:0] root_plus_r;
  logic signed [OUT_WIDTH-1:0] root_minus_r;
  logic                        no_real_r;

  assign q_max = CW'($signed({1'b0, {(OUT_WIDTH-1){1'b1}}}));
  assign q_min = CW'($signed({1'b1, {(OUT_WIDTH-1){1'b0}}}));
  assign qp    = dv_negp ? -CW'($signed({1'b0, dv_qp})) : CW'($signed({1'b0, dv_qp}));
  assign qm    = dv_negm ? -CW'($signed({1'b0, dv_qm})) : CW'($signed({1'b0, dv_qm}));

  always_comb begin
    if (qp > q_max) begin
      qp_sat = OUT_WIDTH'(q_max);
    end else if (qp < q_min) begin
      qp_sat = OUT_WIDTH'(q_min);
    end else begin
      qp_sat = OUT_WIDTH'(qp);
    end
    if (qm > q_max) begin
      qm_sat = OUT_WIDTH'(q_max);
    end else if (qm < q_min) begin
      qm_sat = OUT_WIDTH'(q_min);
    end else begin
      qm_sat = OUT_WIDTH'(qm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      root_plus_r  <= dv_flag ? '0 : qp_sat;
      root_minus_r <= dv_flag ? '0 : qm_sat;
      no_real_r    <= dv_flag;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_root_plus     = root_plus_r;
  assign out_root_minus    = root_minus_r;
  assign out_no_real_roots = no_real_r;

  // A flagged result carries zero roots.
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_real_roots |-> out_root_plus == '0 && out_root_minus == '0)
    else $error("flagged result with nonzero roots");

  // Input side stalls exactly when a finished result is held.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to held output");

  // A frozen pipeline keeps its first-stage contents.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.adv |=> $stable(s1_v_r) && $stable(s1_bb_r))
    else $error("stage moved while stalled");

  // With a positive a and a real result, the plus root is not below the minus root.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !s3_flag_r && !s3_den_r[DENW-1] |-> s3_np_r >= s3_nm_r)
    else $error("numerator order broken");

endmodule
